@@ sv/cidg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and base-36 helpers for the identifier generator.
package cidg_pkg;

   localparam int ID_LEN       = 25;
   localparam int DIGITS       = ID_LEN - 1;
   localparam int BEAT_W       = $clog2(ID_LEN);
   localparam int ITEM_DEPTH   = 2;
   localparam int RESULT_DEPTH = 2;

   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(ID_LEN - 1);

   localparam logic [20:0] SEQ_LIMIT = 21'd1679616;

   localparam logic [6:0] CHAR_C    = 7'h63;
   localparam logic [6:0] CHAR_ZERO = 7'h30;
   localparam logic [6:0] CHAR_A    = 7'h61;

   // ceil(2^35 / 36); exact quotient for every dividend below 2^33
   localparam logic [29:0] DIV36_MUL   = 30'd954437177;
   localparam int          DIV36_SHIFT = 35;

   // configuration register indexes
   localparam logic CSR_PROCESS_ID = 1'b0;
   localparam logic CSR_HOST_SUM   = 1'b1;

   typedef logic [5:0] digit_type;

   typedef struct packed {
      logic [47:0] time_ms;
      logic [20:0] seq;
      logic [21:0] process_id;
      logic [15:0] host_sum;
      logic [30:0] random_a;
      logic [30:0] random_b;
   } item_type;

   typedef struct packed {
      logic                          valid;
      logic [DIGITS-1:0][5:0]        digits;
   } dig_bus_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last_char;
   } rsp_type;

   function automatic logic [26:0] div36(input logic [31:0] x);
      logic [61:0] prod;
      prod = {30'b0, x} * {32'b0, DIV36_MUL};
      return prod[61:DIV36_SHIFT];
   endfunction

   function automatic digit_type rem36(input logic [31:0] x, input logic [26:0] q);
      logic [31:0] diff;
      diff = x - ({q, 5'b0} + {3'b0, q, 2'b0});
      return diff[5:0];
   endfunction

   function automatic logic [6:0] digit_char(input digit_type d);
      if (d <= 6'd9) begin
         return CHAR_ZERO + {1'b0, d};
      end
      return CHAR_A + {1'b0, d} - 7'd10;
   endfunction

endpackage

@@ sv/collision_resistant_id_generator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the collision-resistant identifier generator.
// A request beat passes the item queue, the converter, the emitter and the
// result queue; the first character ('c') leads and the remaining 24 follow
// one per cycle while the result queue has room. Requests are taken while
// one is in flight: base-36 conversion overlaps the previous item's emission.
// Reset (synchronous, active high) clears queues, counter and registers at once.
module collision_resistant_id_generator_unit #(
   parameter int ITEM_DEPTH   = cidg_pkg::ITEM_DEPTH,
   parameter int RESULT_DEPTH = cidg_pkg::RESULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request side: queue write port
   input  logic        push,
   output logic        full,
   input  logic [47:0] req_time_ms,
   input  logic [30:0] req_random_a,
   input  logic [30:0] req_random_b,
   // result side: queue read port, one character per beat
   output logic        empty,
   input  logic        pop,
   output logic [6:0]  rsp_character,
   output logic        rsp_last_char,
   // configuration writes
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [21:0] csr_wdata
);

   localparam int ITEM_W = $bits(cidg_pkg::item_type);
   localparam int RSP_W  = $bits(cidg_pkg::rsp_type);

   cidg_pkg::item_type    f_item;
   cidg_pkg::item_type    c_item;
   logic                  f_push;
   logic                  iq_full;
   logic                  iq_empty;
   logic                  c_pop;
   cidg_pkg::dig_bus_type dig;
   logic                  take;
   logic                  e_push;
   logic                  rq_full;
   cidg_pkg::rsp_type     e_data;
   cidg_pkg::rsp_type     r_data;

   // Front: count the request, snapshot the registers, hand the item on.
   cidg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .req_time_ms  (req_time_ms),
      .req_random_a (req_random_a),
      .req_random_b (req_random_b),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (iq_full),
      .q_push       (f_push),
      .q_item       (f_item)
   );

   // Item queue decouples request acceptance from the converter.
   cidg_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (ITEM_DEPTH)
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (f_item),
      .full  (iq_full),
      .pop   (c_pop),
      .rdata (c_item),
      .empty (iq_empty)
   );

   assign full = iq_full;

   // Converter: time lane plus shared lane for the rest.
   cidg_conv u_conv (
      .clock   (clock),
      .reset   (reset),
      .q_empty (iq_empty),
      .q_item  (c_item),
      .q_pop   (c_pop),
      .dig     (dig),
      .take    (take)
   );

   // Emitter: takes a finished digit buffer and streams 25 characters.
   cidg_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .dig      (dig),
      .take     (take),
      .out_full (rq_full),
      .out_push (e_push),
      .out_data (e_data)
   );

   // Result queue: holds finished characters while the consumer stalls.
   cidg_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RESULT_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (e_push),
      .wdata (e_data),
      .full  (rq_full),
      .pop   (pop),
      .rdata (r_data),
      .empty (empty)
   );

   assign rsp_character = r_data.character;
   assign rsp_last_char = r_data.last_char;

endmodule

@@ sv/cidg_fifo.sv @@
`timescale 1ns / 1ps
// Small register queue with fall-through read.
module cidg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = (count_ff == CNT_W'(DEPTH));
      empty   = (count_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      rdata   = mem_ff[rptr_ff];

      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_push_only_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not advance on push");

endmodule

@@ sv/cidg_front.sv @@
`timescale 1ns / 1ps
// Front end: request accept, sequence counter and configuration registers.
module cidg_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [47:0]        req_time_ms,
   input  logic [30:0]        req_random_a,
   input  logic [30:0]        req_random_b,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [21:0]        csr_wdata,
   input  logic               q_full,
   output logic               q_push,
   output cidg_pkg::item_type q_item
);

   logic [20:0] seq_ff, seq_in;
   logic [21:0] pid_ff;
   logic [15:0] host_ff;

   always_comb begin
      q_push = push && !q_full;
      seq_in = (seq_ff >= cidg_pkg::SEQ_LIMIT) ? 21'd1 : seq_ff + 21'd1;

      q_item.time_ms    = req_time_ms;
      q_item.seq        = seq_ff;
      q_item.process_id = pid_ff;
      q_item.host_sum   = host_ff;
      q_item.random_a   = req_random_a;
      q_item.random_b   = req_random_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= '0;
         pid_ff  <= '0;
         host_ff <= '0;
      end else begin
         if (q_push) begin
            seq_ff <= seq_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               cidg_pkg::CSR_PROCESS_ID: pid_ff  <= csr_wdata;
               cidg_pkg::CSR_HOST_SUM:   host_ff <= csr_wdata[15:0];
               default:                  pid_ff  <= pid_ff;
            endcase
         end
      end
   end

   a_seq_range: assert property (@(posedge clock) disable iff (reset)
      seq_ff <= cidg_pkg::SEQ_LIMIT)
      else $error("sequence counter left its range");

endmodule

@@ sv/cidg_conv.sv @@
`timescale 1ns / 1ps
// Back end converter: base-36 digit extraction into a digit buffer.
module cidg_conv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  cidg_pkg::item_type    q_item,
   output logic                  q_pop,
   output cidg_pkg::dig_bus_type dig,
   input  logic                  take
);

   // other-lane schedule: random_b, random_a, host_sum, process_id, counter,
   // each low digit first, so the shift buffer ends most significant first
   localparam logic [3:0] CYC_LOAD_RA   = 4'd3;
   localparam logic [3:0] CYC_LOAD_HOST = 4'd7;
   localparam logic [3:0] CYC_LOAD_PID  = 4'd9;
   localparam logic [3:0] CYC_LOAD_SEQ  = 4'd11;
   localparam logic [3:0] CYC_LAST      = 4'd15;

   cidg_pkg::item_type     item_ff;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [3:0]             cyc_ff, cyc_in;
   logic [23:0]            thi_ff, thi_in;
   logic [23:0]            tlo_ff, tlo_in;
   cidg_pkg::digit_type    trem_ff, trem_in;
   logic [30:0]            w_ff, w_in;
   logic [7:0][5:0]        tdig_ff, tdig_in;
   logic [15:0][5:0]       odig_ff, odig_in;
   logic [31:0]            t_x, w_x;
   logic [26:0]            t_q, w_q;
   cidg_pkg::digit_type    t_r, w_r;
   logic                   load;

   always_comb begin
      load  = !busy_ff && !done_ff && !q_empty;
      q_pop = load;

      // time lane alternates: high half on even cycles, low half on odd
      t_x = cyc_ff[0] ? {2'b0, trem_ff, tlo_ff} : {8'b0, thi_ff};
      t_q = cidg_pkg::div36(t_x);
      t_r = cidg_pkg::rem36(t_x, t_q);

      w_x = {1'b0, w_ff};
      w_q = cidg_pkg::div36(w_x);
      w_r = cidg_pkg::rem36(w_x, w_q);

      busy_in = busy_ff;
      done_in = done_ff && !take;
      cyc_in  = cyc_ff;
      thi_in  = thi_ff;
      tlo_in  = tlo_ff;
      trem_in = trem_ff;
      w_in    = w_ff;
      tdig_in = tdig_ff;
      odig_in = odig_ff;

      if (load) begin
         busy_in = 1'b1;
         cyc_in  = '0;
         thi_in  = q_item.time_ms[47:24];
         tlo_in  = q_item.time_ms[23:0];
         w_in    = q_item.random_b;
      end else if (busy_ff) begin
         cyc_in = cyc_ff + 4'd1;
         if (cyc_ff == CYC_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (cyc_ff[0]) begin
            tlo_in  = t_q[23:0];
            tdig_in = {tdig_ff[6:0], t_r};
         end else begin
            thi_in  = t_q[23:0];
            trem_in = t_r;
         end
         odig_in = {odig_ff[14:0], w_r};
         unique case (cyc_ff)
            CYC_LOAD_RA:   w_in = item_ff.random_a;
            CYC_LOAD_HOST: w_in = {15'b0, item_ff.host_sum};
            CYC_LOAD_PID:  w_in = {9'b0, item_ff.process_id};
            CYC_LOAD_SEQ:  w_in = {10'b0, item_ff.seq};
            default:       w_in = {4'b0, w_q};
         endcase
      end

      dig.valid  = done_ff;
      dig.digits = {odig_ff, tdig_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cyc_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cyc_ff  <= cyc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= q_item;
      end
      thi_ff  <= thi_in;
      tlo_ff  <= tlo_in;
      trem_ff <= trem_in;
      w_ff    <= w_in;
      tdig_ff <= tdig_in;
      odig_ff <= odig_in;
   end

   a_finish: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cyc_ff == CYC_LAST) |=> (done_ff && !busy_ff))
      else $error("converter did not finish after its last step");

endmodule

@@ sv/cidg_emit.sv @@
`timescale 1ns / 1ps
// Back end emitter: walks the digit buffer one character per beat.
module cidg_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  cidg_pkg::dig_bus_type dig,
   output logic                  take,
   input  logic                  out_full,
   output logic                  out_push,
   output cidg_pkg::rsp_type     out_data
);

   logic                                    busy_ff, busy_in;
   logic [cidg_pkg::BEAT_W-1:0]             beat_ff, beat_in;
   logic [cidg_pkg::DIGITS-1:0][5:0]        shift_ff, shift_in;
   logic                                    last;

   always_comb begin
      out_push = busy_ff && !out_full;
      last     = (beat_ff == cidg_pkg::LAST_BEAT);
      take     = dig.valid && (!busy_ff || (out_push && last));

      out_data.character = (beat_ff == '0) ? cidg_pkg::CHAR_C
                                           : cidg_pkg::digit_char(shift_ff[0]);
      out_data.last_char = last;

      busy_in  = busy_ff;
      beat_in  = beat_ff;
      shift_in = shift_ff;
      if (take) begin
         busy_in  = 1'b1;
         beat_in  = '0;
         shift_in = dig.digits;
      end else if (out_push) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + cidg_pkg::BEAT_W'(1);
         end
         if (beat_ff != '0) begin
            shift_in = {6'b0, shift_ff[cidg_pkg::DIGITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      beat_ff <= cidg_pkg::LAST_BEAT)
      else $error("beat index beyond identifier length");

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (out_push && last) |=> (!busy_ff || beat_ff == '0))
      else $error("identifier did not restart after last beat");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the identifier generator: directed and random requests.
module testbench;

   // field spans: values are shown modulo these, so a span itself gives zero digits
   localparam longint unsigned TIME_SPAN = 64'd2821109907456;  // 36^8
   localparam int unsigned     WORD_SPAN = 1679616;            // 36^4
   localparam int unsigned     FP_SPAN   = 1296;               // 36^2

   logic        clock;
   logic        reset        = 1'b1;
   logic        push         = 1'b0;
   logic        full;
   logic [47:0] req_time_ms  = '0;
   logic [30:0] req_random_a = '0;
   logic [30:0] req_random_b = '0;
   logic        empty;
   logic        pop          = 1'b0;
   logic [6:0]  rsp_character;
   logic        rsp_last_char;
   logic        csr_wr_en    = 1'b0;
   logic        csr_index    = cidg_pkg::CSR_PROCESS_ID;
   logic [21:0] csr_wdata    = '0;

   // predictor state, starts at its reset values since reset is applied once
   logic [20:0] seq_count      = '0;
   logic [21:0] cfg_process_id = '0;
   logic [15:0] cfg_host_sum   = '0;

   cidg_pkg::rsp_type pending_chars[$];   // expected characters, oldest first
   logic [6:0]        id_text[$];         // identifier under construction
   int                mismatch_count = 0;
   bit                steady         = 1'b0;   // when set, neither side idles

   collision_resistant_id_generator_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_time_ms   (req_time_ms),
      .req_random_a  (req_random_a),
      .req_random_b  (req_random_b),
      .empty         (empty),
      .pop           (pop),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic logic [6:0] base36_char(input int unsigned d);
      if (d < 10) begin
         return cidg_pkg::CHAR_ZERO + 7'(d);
      end
      return cidg_pkg::CHAR_A + 7'(d - 10);
   endfunction

   // Append the low n base-36 digits of v, most significant first.
   function automatic void append_digits(input longint unsigned v, input int n);
      logic [6:0] digs[8];
      for (int i = n - 1; i >= 0; i--) begin
         digs[i] = base36_char(int'(v % 36));
         v = v / 36;
      end
      for (int i = 0; i < n; i++) begin
         id_text.push_back(digs[i]);
      end
   endfunction

   // Build the whole identifier for one accepted request and queue its beats.
   function automatic void predict_identifier(input logic [47:0] t, input logic [30:0] ra,
                                              input logic [30:0] rb);
      logic [20:0]       cnt;
      cidg_pkg::rsp_type beat;
      cnt = seq_count;
      // the counter shows 0..SEQ_LIMIT and then restarts at one, never zero
      seq_count = (cnt >= cidg_pkg::SEQ_LIMIT) ? 21'd1 : cnt + 21'd1;
      id_text.delete();
      id_text.push_back(cidg_pkg::CHAR_C);
      append_digits(64'(t), 8);
      append_digits(64'(cnt), 4);
      append_digits(64'(cfg_process_id), 2);
      append_digits(64'(cfg_host_sum), 2);
      append_digits(64'(ra), 4);
      append_digits(64'(rb), 4);
      foreach (id_text[k]) begin
         beat.character = id_text[k];
         beat.last_char = (k == cidg_pkg::ID_LEN - 1);
         pending_chars.push_back(beat);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Hold push high until the request beat is taken; push stays high on
   // return so a back-to-back request needs no second assignment.
   task automatic send_request(input logic [47:0] t, input logic [30:0] ra,
                               input logic [30:0] rb);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push         <= 1'b1;
      req_time_ms  <= t;
      req_random_a <= ra;
      req_random_b <= rb;
      do @(posedge clock); while (full);
      predict_identifier(t, ra, rb);
   endtask

   task automatic send_random_request();
      logic [47:0] t;
      logic [30:0] ra;
      logic [30:0] rb;
      // mostly full-width values, some small ones to keep leading zeros busy
      case ($urandom_range(0, 3))
         0: t = 48'($urandom_range(0, FP_SPAN));
         1: t = 48'(TIME_SPAN - 64'($urandom_range(0, FP_SPAN)));
         default: t = {16'($urandom), 32'($urandom)};
      endcase
      ra = ($urandom_range(0, 4) == 0) ? 31'($urandom_range(0, FP_SPAN)) : 31'($urandom);
      rb = ($urandom_range(0, 4) == 0) ? 31'($urandom_range(0, FP_SPAN)) : 31'($urandom);
      send_request(t, ra, rb);
   endtask

   // Drop push and wait for every expected character, plus an optional tail.
   task automatic drain_results(input int extra);
      push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // Write both registers back to back; call only while the block is idle.
   task automatic apply_config(input logic [21:0] pid, input logic [15:0] hs);
      csr_wr_en <= 1'b1;
      csr_index <= cidg_pkg::CSR_PROCESS_ID;
      csr_wdata <= pid;
      @(posedge clock);
      csr_index <= cidg_pkg::CSR_HOST_SUM;
      csr_wdata <= {6'd0, hs};
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      cfg_process_id = pid;
      cfg_host_sum   = hs;
   endtask

   // ---------------------------------------------------------------------
   // Result side: draw a stall after each beat, compare against the oldest
   // expectation. Outputs are read right at the edge, before they update.
   // ---------------------------------------------------------------------
   initial begin : result_monitor
      cidg_pkg::rsp_type want;
      int                stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            if (pending_chars.size() == 0) begin
               $error("unexpected beat: character %h last_char %b",
                      rsp_character, rsp_last_char);
               mismatch_count++;
            end else begin
               want = pending_chars.pop_front();
               if (rsp_character !== want.character) begin
                  $error("character: expected %h, actual %h", want.character, rsp_character);
                  mismatch_count++;
               end
               if (rsp_last_char !== want.last_char) begin
                  $error("last_char: expected %b, actual %b", want.last_char, rsp_last_char);
                  mismatch_count++;
               end
            end
            stall = steady ? 0 : $urandom_range(0, 4);
         end
         if (stall > 0) begin
            pop <= 1'b0;
            stall--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Registers at their reset values; counter starts at zero.
   task automatic test_reset_config();
      send_request('0, '0, '0);
      send_request(48'd1, 31'd1, 31'd1);
   endtask

   // Field extremes, truncation at each span and the digit/letter edges.
   task automatic test_field_extremes();
      send_request('1, '1, '1);
      send_request(48'(TIME_SPAN - 1), 31'(WORD_SPAN - 1), 31'(WORD_SPAN - 1));
      send_request(48'(TIME_SPAN), 31'(WORD_SPAN), 31'(WORD_SPAN));
      send_request(48'd35, 31'd9, 31'd10);
      send_request(48'd36, 31'd10, 31'd35);
      send_request(48'h8000_0000_0000, 31'h4000_0000, '0);
   endtask

   // Register extremes: full width, all-'z' digits, wrap to "00", digit edge.
   task automatic test_config_extremes();
      logic [21:0] pids[4];
      logic [15:0] sums[4];
      pids = '{22'h3F_FFFF, 22'(FP_SPAN - 1), 22'(FP_SPAN), 22'd10};
      sums = '{16'hFFFF,    16'(FP_SPAN - 1), 16'(FP_SPAN), 16'd9};
      for (int s = 0; s < 4; s++) begin
         drain_results(0);
         apply_config(pids[s], sums[s]);
         repeat (2) send_random_request();
      end
   endtask

   // Random requests in phases, each under its own register setting; every
   // third phase runs with no idling on either side.
   task automatic test_random_traffic();
      logic [21:0] pid;
      logic [15:0] hs;
      for (int p = 0; p < 6; p++) begin
         drain_results(0);
         case (p)
            1: begin
               pid = 22'h3F_FFFF;
               hs  = '0;
            end
            4: begin
               pid = '0;
               hs  = 16'hFFFF;
            end
            default: begin
               pid = 22'($urandom);
               hs  = 16'($urandom);
            end
         endcase
         apply_config(pid, hs);
         steady = (p % 3 == 2);
         repeat (45) send_random_request();
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset, tests in turn, drain, verdict
   // ---------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_config();
      test_field_extremes();
      test_config_extremes();
      test_random_traffic();
      // wait out any stray beats after the last expected one
      drain_results(2 * cidg_pkg::ID_LEN);
      if (mismatch_count == 0) begin
         $display("collision_resistant_id_generator_unit: match");
      end else begin
         $display("collision_resistant_id_generator_unit: mismatch");
      end
      $finish;
   end

   // Hang guard: the slowest run is well under half a millisecond.
   initial begin
      #4_000_000;
      $display("collision_resistant_id_generator_unit: mismatch");
      $finish;
   end

endmodule

@@ files.f @@
sv/cidg_pkg.sv
sv/cidg_fifo.sv
sv/cidg_front.sv
sv/cidg_conv.sv
sv/cidg_emit.sv
sv/collision_resistant_id_generator_unit.sv
test/testbench.sv
